// ===== design/ffha_pkg.sv =====
`timescale 1ns / 1ps

package ffha_pkg;

    localparam int SW = 20;
    localparam int OW = 21;
    localparam int LW = 20;
    localparam int KW = 2;
    localparam int STW = 2;
    localparam int AW = 22;
    localparam int IN_DW = 48;
    localparam int OUT_DW = 64;

    localparam int GRAN = 16;
    localparam int GRAN_M1 = 15;

    localparam logic [STW-1:0] ST_OK = 2'd0;
    localparam logic [STW-1:0] ST_OOM = 2'd1;
    localparam logic [STW-1:0] ST_NULL = 2'd2;
    localparam logic [STW-1:0] ST_UNKNOWN = 2'd3;

    typedef enum logic [KW-1:0] {
        K_ALLOC  = 2'd0,
        K_FREE   = 2'd1,
        K_RESIZE = 2'd2
    } kind_t;

    typedef struct packed {
        logic [SW-1:0] start;
        logic [SW-1:0] size;
        logic          free;
    } entry_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_INIT,
        OP_LOAD,
        OP_SCAN_START,
        OP_SCAN,
        OP_CAP_NXT,
        OP_RES_OFF,
        OP_SAVE_OLD,
        OP_MOVE_OUT,
        OP_SHUP_START,
        OP_SHUP,
        OP_SPLIT_WR,
        OP_TAKE_WR,
        OP_REL_WR,
        OP_MRG_NEXT,
        OP_MRG_PREV,
        OP_SHDN,
        OP_PUBLISH
    } op_t;

    typedef struct packed {
        op_t            op;
        logic           fit;
        logic           st_we;
        logic [STW-1:0] st;
    } cmd_t;

    typedef struct packed {
        logic  hit;
        logic  miss;
        logic  has_nxt;
        logic  nxt_free;
        logic  has_prv;
        logic  prv_free;
        logic  keep;
        logic  absorb;
        logic  split_ok;
        logic  sweep_done;
        logic  out_free;
        logic  size_zero;
        logic  off_zero;
        logic [KW-1:0] kind;
    } sts_t;

endpackage

// ===== design/ffha_dp.sv =====
`timescale 1ns / 1ps

module ffha_dp #(
    parameter int HEAP_BYTES = 1048576,
    parameter int HEADER_BYTES = 40,
    parameter int MAX_BLOCKS = 256
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ffha_pkg::cmd_t               cmd,
    output ffha_pkg::sts_t               sts,
    input  logic [ffha_pkg::IN_DW-1:0]   s_tdata,
    input  logic [ffha_pkg::KW-1:0]      s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [ffha_pkg::OUT_DW-1:0]  m_tdata,
    output logic [ffha_pkg::STW-1:0]     m_tuser
);
    import ffha_pkg::*;

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = IW + 1;
    localparam logic [AW-1:0] HDR = AW'(HEADER_BYTES);
    localparam logic [SW-1:0] INIT_SIZE = SW'(HEAP_BYTES - HEADER_BYTES);
    localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

    entry_t mem_reg [MAX_BLOCKS];
    entry_t rd_data_reg;

    logic [KW-1:0]  kind_reg;
    logic [OW-1:0]  size_reg;
    logic [OW-1:0]  off_reg;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  sidx_reg;
    logic [CW-1:0]  rd_idx_reg;
    logic           rd_vld_reg;
    logic [CW-1:0]  idx_reg;
    entry_t         cur_reg;
    entry_t         nxt_reg;
    entry_t         prv_reg;
    logic           split_reg;
    logic [SW-1:0]  old_size_reg;
    logic [OW-1:0]  res_reg;
    logic [OW-1:0]  src_reg;
    logic [LW-1:0]  len_reg;
    logic [STW-1:0] st_reg;
    logic           m_tvalid_reg;
    logic [OUT_DW-1:0] m_tdata_reg;
    logic [STW-1:0] m_tuser_reg;

    logic [AW-1:0] aligned;
    logic [AW-1:0] nsum;
    logic [AW-1:0] psum;
    logic [CW-1:0] rd_up;
    logic [CW-1:0] rd_dn;
    logic [CW-1:0] idx_up;
    logic [CW-1:0] idx_dn;
    logic          rd_live;
    logic          match_find;
    logic          match_fit;
    logic          hit;
    logic          issue;
    logic          sweep_done;
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    entry_t        mem_wd;

    always_comb begin
        aligned = (AW'(size_reg) + AW'(GRAN_M1)) & ~AW'(GRAN_M1);
        nsum = AW'(cur_reg.size) + HDR + AW'(nxt_reg.size);
        psum = AW'(prv_reg.size) + HDR + AW'(cur_reg.size);
        rd_up = rd_idx_reg + CW'(1);
        rd_dn = rd_idx_reg - CW'(1);
        idx_up = idx_reg + CW'(1);
        idx_dn = idx_reg - CW'(1);
        rd_live = rd_vld_reg && (rd_idx_reg < cnt_reg);
        match_find = (OW'(rd_data_reg.start) + OW'(HEADER_BYTES)) == off_reg;
        match_fit = rd_data_reg.free && (AW'(rd_data_reg.size) >= aligned);
        hit = rd_live && (cmd.fit ? match_fit : match_find);
        case (cmd.op)
            OP_SCAN: issue = 1'b1;
            OP_SHUP: issue = sidx_reg > idx_reg;
            OP_SHDN: issue = sidx_reg < cnt_reg;
            default: issue = 1'b0;
        endcase
        sweep_done = !issue && !rd_vld_reg;
    end

    always_comb begin
        sts.hit = (cmd.op == OP_SCAN) && hit;
        sts.miss = (cmd.op == OP_SCAN) && rd_vld_reg && (rd_idx_reg >= cnt_reg);
        sts.has_nxt = idx_up < cnt_reg;
        sts.nxt_free = nxt_reg.free;
        sts.has_prv = idx_reg != '0;
        sts.prv_free = prv_reg.free;
        sts.keep = OW'(cur_reg.size) >= size_reg;
        sts.absorb = (idx_up < cnt_reg) && nxt_reg.free && (nsum >= AW'(size_reg));
        sts.split_ok = (AW'(cur_reg.size) > aligned + HDR + AW'(GRAN)) && (cnt_reg < MAXC);
        sts.sweep_done = sweep_done;
        sts.out_free = !m_tvalid_reg || m_tready;
        sts.size_zero = size_reg == '0;
        sts.off_zero = off_reg == '0;
        sts.kind = kind_reg;
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = idx_reg[IW-1:0];
        mem_wd = rd_data_reg;
        case (cmd.op)
            OP_INIT: begin
                mem_we = 1'b1;
                mem_wa = '0;
                mem_wd = '{start: '0, size: INIT_SIZE, free: 1'b1};
            end
            OP_SHUP: begin
                mem_we = rd_vld_reg;
                mem_wa = rd_up[IW-1:0];
            end
            OP_SHDN: begin
                mem_we = rd_vld_reg;
                mem_wa = rd_dn[IW-1:0];
            end
            OP_SPLIT_WR: begin
                mem_we = 1'b1;
                mem_wa = idx_up[IW-1:0];
                mem_wd.start = SW'(AW'(cur_reg.start) + HDR + aligned);
                mem_wd.size = SW'(AW'(cur_reg.size) - aligned - HDR);
                mem_wd.free = 1'b1;
            end
            OP_TAKE_WR: begin
                mem_we = 1'b1;
                mem_wd.start = cur_reg.start;
                mem_wd.size = split_reg ? aligned[SW-1:0] : cur_reg.size;
                mem_wd.free = 1'b0;
            end
            OP_REL_WR: begin
                mem_we = 1'b1;
                mem_wd = '{start: cur_reg.start, size: cur_reg.size, free: 1'b1};
            end
            OP_MRG_NEXT: begin
                mem_we = 1'b1;
                mem_wd = '{start: cur_reg.start, size: nsum[SW-1:0], free: cur_reg.free};
            end
            OP_MRG_PREV: begin
                mem_we = 1'b1;
                mem_wa = idx_dn[IW-1:0];
                mem_wd = '{start: prv_reg.start, size: psum[SW-1:0], free: prv_reg.free};
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_reg[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem_reg[sidx_reg[IW-1:0]];
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= sidx_reg;
        if (cmd.st_we) begin
            st_reg <= cmd.st;
        end
        case (cmd.op)
            OP_LOAD: begin
                kind_reg <= s_tuser;
                size_reg <= s_tdata[OW-1:0];
                off_reg <= s_tdata[2*OW-1:OW];
                res_reg <= '0;
                src_reg <= '0;
                len_reg <= '0;
                st_reg <= ST_OK;
            end
            OP_SCAN_START: begin
                sidx_reg <= '0;
                split_reg <= 1'b0;
            end
            OP_SCAN: begin
                sidx_reg <= sidx_reg + CW'(1);
                if (hit) begin
                    cur_reg <= rd_data_reg;
                    idx_reg <= rd_idx_reg;
                end else if (rd_live) begin
                    prv_reg <= rd_data_reg;
                end
            end
            OP_CAP_NXT: nxt_reg <= rd_data_reg;
            OP_RES_OFF: res_reg <= off_reg;
            OP_SAVE_OLD: old_size_reg <= cur_reg.size;
            OP_MOVE_OUT: begin
                src_reg <= off_reg;
                len_reg <= old_size_reg;
            end
            OP_SHUP_START: begin
                sidx_reg <= cnt_reg - CW'(1);
                split_reg <= 1'b1;
            end
            OP_SHUP: begin
                if (issue) begin
                    sidx_reg <= sidx_reg - CW'(1);
                end
            end
            OP_TAKE_WR: res_reg <= OW'(cur_reg.start) + OW'(HEADER_BYTES);
            OP_REL_WR: cur_reg.free <= 1'b1;
            OP_MRG_NEXT: begin
                cur_reg.size <= nsum[SW-1:0];
                sidx_reg <= idx_reg + CW'(2);
            end
            OP_MRG_PREV: begin
                cur_reg <= '{start: prv_reg.start, size: psum[SW-1:0], free: prv_reg.free};
                idx_reg <= idx_dn;
                sidx_reg <= idx_up;
            end
            OP_SHDN: begin
                if (issue) begin
                    sidx_reg <= sidx_reg + CW'(1);
                end
            end
            OP_PUBLISH: begin
                m_tdata_reg <= {2'b00, len_reg, src_reg, res_reg};
                m_tuser_reg <= st_reg;
            end
            default: begin
                split_reg <= split_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= CW'(1);
            rd_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            rd_vld_reg <= issue;
            if (cmd.op == OP_INIT) begin
                cnt_reg <= CW'(1);
            end else if (cmd.op == OP_SPLIT_WR) begin
                cnt_reg <= cnt_reg + CW'(1);
            end else if (cmd.op == OP_SHDN && sweep_done) begin
                cnt_reg <= cnt_reg - CW'(1);
            end
            if (cmd.op == OP_PUBLISH) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

endmodule

// ===== design/ffha_ctrl.sv =====
`timescale 1ns / 1ps

module ffha_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  ffha_pkg::sts_t sts,
    output ffha_pkg::cmd_t cmd
);
    import ffha_pkg::*;

    typedef enum logic [17:0] {
        S_INIT  = 18'h00001,
        S_IDLE  = 18'h00002,
        S_DISP  = 18'h00004,
        S_SCAN0 = 18'h00008,
        S_SCAN  = 18'h00010,
        S_NXT   = 18'h00020,
        S_DEC   = 18'h00040,
        S_SHUP0 = 18'h00080,
        S_SHUP  = 18'h00100,
        S_SPLIT = 18'h00200,
        S_TAKE  = 18'h00400,
        S_REL   = 18'h00800,
        S_MNXT  = 18'h01000,
        S_SHDN1 = 18'h02000,
        S_PCHK  = 18'h04000,
        S_MPRV  = 18'h08000,
        S_SHDN2 = 18'h10000,
        S_DONE  = 18'h20000
    } state_t;

    typedef enum logic [3:0] {
        PH_FIT   = 4'b0001,
        PH_FIND  = 4'b0010,
        PH_MFIT  = 4'b0100,
        PH_MFIND = 4'b1000
    } phase_t;

    state_t state_reg, state_next;
    phase_t ph_reg, ph_next;
    logic   rel_reg, rel_next;

    always_comb begin
        state_next = state_reg;
        ph_next = ph_reg;
        rel_next = rel_reg;
        s_tready = 1'b0;
        cmd.op = OP_NOP;
        cmd.fit = (ph_reg == PH_FIT) || (ph_reg == PH_MFIT);
        cmd.st_we = 1'b0;
        cmd.st = ST_OK;
        unique case (state_reg)
            S_INIT: begin
                cmd.op = OP_INIT;
                state_next = S_IDLE;
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op = OP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                case (sts.kind)
                    K_ALLOC: begin
                        if (sts.size_zero) begin
                            cmd.st_we = 1'b1;
                            cmd.st = ST_NULL;
                            state_next = S_DONE;
                        end else begin
                            ph_next = PH_FIT;
                            state_next = S_SCAN0;
                        end
                    end
                    K_FREE: begin
                        if (sts.off_zero) begin
                            cmd.st_we = 1'b1;
                            cmd.st = ST_NULL;
                            state_next = S_DONE;
                        end else begin
                            ph_next = PH_FIND;
                            state_next = S_SCAN0;
                        end
                    end
                    K_RESIZE: begin
                        if (!sts.off_zero) begin
                            ph_next = PH_FIND;
                            state_next = S_SCAN0;
                        end else if (sts.size_zero) begin
                            cmd.st_we = 1'b1;
                            cmd.st = ST_NULL;
                            state_next = S_DONE;
                        end else begin
                            ph_next = PH_FIT;
                            state_next = S_SCAN0;
                        end
                    end
                    default: begin
                        cmd.st_we = 1'b1;
                        cmd.st = ST_NULL;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN0: begin
                cmd.op = OP_SCAN_START;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                cmd.op = OP_SCAN;
                if (sts.hit) begin
                    state_next = S_NXT;
                end else if (sts.miss) begin
                    state_next = S_DONE;
                    if (ph_reg == PH_FIND) begin
                        cmd.st_we = 1'b1;
                        cmd.st = ST_UNKNOWN;
                    end else if (ph_reg != PH_MFIND) begin
                        cmd.st_we = 1'b1;
                        cmd.st = ST_OOM;
                    end
                end
            end
            S_NXT: begin
                cmd.op = OP_CAP_NXT;
                state_next = S_DEC;
            end
            S_DEC: begin
                rel_next = 1'b1;
                if (ph_reg == PH_FIT || ph_reg == PH_MFIT) begin
                    if (ph_reg == PH_MFIT) begin
                        cmd.op = OP_MOVE_OUT;
                    end
                    state_next = sts.split_ok ? S_SHUP0 : S_TAKE;
                end else if (ph_reg == PH_MFIND || sts.kind == K_FREE) begin
                    state_next = S_REL;
                end else if (sts.size_zero) begin
                    cmd.st_we = 1'b1;
                    cmd.st = ST_NULL;
                    state_next = S_REL;
                end else if (sts.keep) begin
                    cmd.op = OP_RES_OFF;
                    state_next = S_DONE;
                end else if (sts.absorb) begin
                    cmd.op = OP_RES_OFF;
                    rel_next = 1'b0;
                    state_next = S_MNXT;
                end else begin
                    cmd.op = OP_SAVE_OLD;
                    ph_next = PH_MFIT;
                    state_next = S_SCAN0;
                end
            end
            S_SHUP0: begin
                cmd.op = OP_SHUP_START;
                state_next = S_SHUP;
            end
            S_SHUP: begin
                cmd.op = OP_SHUP;
                if (sts.sweep_done) begin
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT: begin
                cmd.op = OP_SPLIT_WR;
                state_next = S_TAKE;
            end
            S_TAKE: begin
                cmd.op = OP_TAKE_WR;
                if (ph_reg == PH_MFIT) begin
                    ph_next = PH_MFIND;
                    state_next = S_SCAN0;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_REL: begin
                cmd.op = OP_REL_WR;
                state_next = (sts.has_nxt && sts.nxt_free) ? S_MNXT : S_PCHK;
            end
            S_MNXT: begin
                cmd.op = OP_MRG_NEXT;
                state_next = S_SHDN1;
            end
            S_SHDN1: begin
                cmd.op = OP_SHDN;
                if (sts.sweep_done) begin
                    state_next = rel_reg ? S_PCHK : S_DONE;
                end
            end
            S_PCHK: begin
                state_next = (sts.has_prv && sts.prv_free) ? S_MPRV : S_DONE;
            end
            S_MPRV: begin
                cmd.op = OP_MRG_PREV;
                state_next = S_SHDN2;
            end
            S_SHDN2: begin
                cmd.op = OP_SHDN;
                if (sts.sweep_done) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.op = OP_PUBLISH;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            ph_reg <= PH_FIT;
            rel_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ph_reg <= ph_next;
            rel_reg <= rel_next;
        end
    end

endmodule

// ===== design/first_fit_heap_allocator.sv =====
`timescale 1ns / 1ps

// First-fit heap allocator over an address-ordered block table held in a
// single-port-write memory that is read one entry per cycle. A request is taken
// only while the block is idle; it takes a table scan, plus a sweep of the table
// for each split or merge (a moving resize scans three times, splits at most once
// and merges at most twice). The result word waits in an output register; the next
// request is taken and worked on meanwhile, but its result is published only once
// that register is free. After reset the block writes the initial free block before
// it accepts a request.
module first_fit_heap_allocator #(
    parameter int HEAP_BYTES = 1048576,
    parameter int HEADER_BYTES = 40,
    parameter int MAX_BLOCKS = 256
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // request_size [20:0], payload_offset [41:21], zero fill [47:42].
    input  logic [ffha_pkg::IN_DW-1:0]   s_tdata,
    // kind [1:0].
    input  logic [ffha_pkg::KW-1:0]      s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // result_offset [20:0], copy_source [41:21], copy_length [61:42], zero fill [63:62].
    output logic [ffha_pkg::OUT_DW-1:0]  m_tdata,
    // status [1:0].
    output logic [ffha_pkg::STW-1:0]     m_tuser
);
    import ffha_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ffha_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffha_dp #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_BLOCKS   (MAX_BLOCKS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== design/ffha_checker.sv =====
`timescale 1ns / 1ps

module ffha_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [ffha_pkg::OUT_DW-1:0]  m_tdata,
    input logic [ffha_pkg::STW-1:0]     m_tuser
);
    import ffha_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Result word changed while stalled.");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("A second request was taken while one was in progress.");

    a_fail_null: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> m_tdata[OW-1:0] == '0)
        else $error("A failed request returned a nonzero offset.");

    a_move_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2*OW+LW-1:2*OW] != '0 |->
            m_tuser == ST_OK && m_tdata[OW-1:0] != '0 && m_tdata[2*OW-1:OW] != '0)
        else $error("A copy was reported without a granted move.");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
